// ===== rtl/core/hafd_pkg.sv =====
// hafd_pkg: shared types and constants of the hex ascii frame deframer
// used by every module in rtl/core, depends on nothing
package hafd_pkg;

    localparam int CHAR_W       = 8;
    localparam int NIB_W        = 4;
    localparam int SRC_W        = 16;
    localparam int LEN_W        = 32;
    localparam int CNT_W        = LEN_W + 1;
    localparam int SUM_W        = 7;
    localparam int ADDR_W       = 32;
    localparam int MAXLEN_W     = 16;
    localparam int TDATA_W      = 64;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0]    MIN_FRAME_BYTES = LEN_W'(9);
    localparam logic [CNT_W-1:0]    HEADER_CHARS    = CNT_W'(18);
    localparam logic [MAXLEN_W-1:0] MAX_FRAME_RESET = MAXLEN_W'(73);

    localparam int  PADDR_W     = 3;
    localparam logic REG_OWN_ADDR  = 1'b0;
    localparam logic REG_MAX_FRAME = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // one classified character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [NIB_W-1:0]  nib;
        logic              hex_ok;
    } hafd_item_t;

    typedef struct packed {
        logic       valid;
        hafd_item_t item;
    } hafd_push_t;

    typedef struct packed {
        logic       valid;
        hafd_item_t item;
    } hafd_qout_t;

    // packed to match tdata, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic              bad_digit;
        logic              too_short;
        logic              too_long;
        logic              checksum_ok;
        logic              address_match;
        logic [LEN_W-1:0]  frame_bytes;
        logic [SRC_W-1:0]  source_address;
        logic [CHAR_W-1:0] data_byte;
    } hafd_result_t;

endpackage

// ===== rtl/core/hafd_front.sv =====
// hafd_front: accepts characters, drops whitespace, decodes hex digits
// depends on hafd_pkg
module hafd_front
(
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [hafd_pkg::CHAR_W-1:0] s_tdata,
    input  logic                        q_full,
    output hafd_pkg::hafd_push_t        push
);
    import hafd_pkg::*;

    logic              is_space;
    logic [NIB_W-1:0]  nib;
    logic              hex_ok;

    always_comb
    begin
        is_space = (s_tdata == 8'd32) || ((s_tdata >= 8'd9) && (s_tdata <= 8'd13));
        hex_ok   = 1'b1;
        nib      = '0;
        if ((s_tdata >= 8'd48) && (s_tdata <= 8'd57))
        begin
            nib = NIB_W'(s_tdata - 8'd48);
        end
        else if ((s_tdata >= 8'd97) && (s_tdata <= 8'd102))
        begin
            nib = NIB_W'(s_tdata - 8'd87);
        end
        else if ((s_tdata >= 8'd65) && (s_tdata <= 8'd70))
        begin
            nib = NIB_W'(s_tdata - 8'd55);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign s_tready         = !q_full;
    assign push.valid       = s_tvalid && !q_full && !is_space;
    assign push.item.ch     = s_tdata;
    assign push.item.nib    = nib;
    assign push.item.hex_ok = hex_ok;

endmodule

// ===== rtl/core/hafd_queue.sv =====
// hafd_queue: short fifo of classified characters between front and back
// depends on hafd_pkg
module hafd_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hafd_pkg::hafd_push_t push,
    input  logic                 pop,
    output logic                 full,
    output hafd_pkg::hafd_qout_t qout
);
    import hafd_pkg::*;

    hafd_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_pop;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign qout.valid = (count_reg != '0);
    assign qout.item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && qout.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ===== rtl/core/hafd_back.sv =====
// hafd_back: frame field sequencer, checksum and status, output register
// depends on hafd_pkg
module hafd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hafd_pkg::hafd_qout_t          qout,
    output logic                          pop,
    input  logic [hafd_pkg::ADDR_W-1:0]   node_addr,
    input  logic [hafd_pkg::MAXLEN_W-1:0] max_frame_bytes,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output hafd_pkg::hafd_result_t        m_result,
    output logic                          m_kind
);
    import hafd_pkg::*;

    typedef enum logic [4:0]
    {
        ST_DEST = 5'b00001,
        ST_SRC  = 5'b00010,
        ST_LEN  = 5'b00100,
        ST_PAY  = 5'b01000,
        ST_SUM  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               match_reg, match_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [NIB_W-1:0]   hi_reg, hi_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               bad_reg, bad_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    hafd_result_t       out_reg, out_next;

    logic               high_pos;
    logic [CHAR_W-1:0]  byte_val;
    logic [CHAR_W-1:0]  expect_ch;
    logic               emit;
    logic               new_frame;

    assign pop      = qout.valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_result = out_reg;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0: expect_ch = node_addr[31:24];
            2'd1: expect_ch = node_addr[23:16];
            2'd2: expect_ch = node_addr[15:8];
            2'd3: expect_ch = node_addr[7:0];
            default: expect_ch = node_addr[7:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        match_next     = match_reg;
        src_next       = src_reg;
        len_next       = len_reg;
        hi_next        = hi_reg;
        sum_next       = sum_reg;
        bad_next       = bad_reg;
        out_kind_next  = out_kind_reg;
        out_next       = out_reg;
        emit           = 1'b0;
        new_frame      = 1'b0;
        high_pos       = !cnt_reg[0];
        byte_val       = {hi_reg, qout.item.nib};

        if (pop)
        begin
            if (!qout.item.hex_ok)
            begin
                bad_next = 1'b1;
            end
            if (high_pos)
            begin
                hi_next = qout.item.nib;
            end
            else if (state_reg != ST_SUM)
            begin
                sum_next = sum_reg + byte_val[SUM_W-1:0];
            end

            unique case (state_reg)
                ST_SRC:
                begin
                    src_next = {src_reg[SRC_W-NIB_W-1:0], qout.item.nib};
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_next = ST_LEN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_LEN:
                begin
                    len_next = {len_reg[LEN_W-NIB_W-1:0], qout.item.nib};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        if (len_next >= MIN_FRAME_BYTES)
                        begin
                            cnt_next   = {len_next, 1'b0} - HEADER_CHARS;
                            state_next = (len_next == MIN_FRAME_BYTES) ? ST_SUM : ST_PAY;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = ST_SUM;
                        end
                    end
                end
                ST_PAY:
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_SUM;
                    end
                    if (!high_pos)
                    begin
                        emit                   = 1'b1;
                        out_kind_next          = KIND_PAYLOAD;
                        out_next               = '0;
                        out_next.data_byte     = byte_val;
                    end
                end
                ST_SUM:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!high_pos)
                    begin
                        emit                       = 1'b1;
                        new_frame                  = 1'b1;
                        out_kind_next              = KIND_STATUS;
                        out_next                   = '0;
                        out_next.source_address    = src_reg;
                        out_next.frame_bytes       = len_reg;
                        out_next.address_match     = match_reg;
                        out_next.checksum_ok       = (byte_val == {1'b0, sum_reg});
                        out_next.too_long          = (len_reg > {16'd0, max_frame_bytes});
                        out_next.too_short         = (len_reg < MIN_FRAME_BYTES);
                        out_next.bad_digit         = bad_reg || !qout.item.hex_ok;
                    end
                end
                ST_DEST:
                begin
                    if (expect_ch != qout.item.ch)
                    begin
                        match_next = 1'b0;
                    end
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_next = ST_SRC;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    new_frame = 1'b1;
                end
            endcase

            if (new_frame)
            begin
                state_next = ST_DEST;
                cnt_next   = '0;
                match_next = 1'b1;
                src_next   = '0;
                len_next   = '0;
                hi_next    = '0;
                sum_next   = '0;
                bad_next   = 1'b0;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DEST;
            cnt_reg       <= '0;
            match_reg     <= 1'b1;
            src_reg       <= '0;
            len_reg       <= '0;
            hi_reg        <= '0;
            sum_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            match_reg     <= match_next;
            src_reg       <= src_next;
            len_reg       <= len_next;
            hi_reg        <= hi_next;
            sum_reg       <= sum_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_reg      <= out_next;
    end

    // payload field always has characters left
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAY |-> cnt_reg != '0)
        else $error("payload phase with empty counter");

    // checksum field holds at most two characters
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> cnt_reg[CNT_W-1:1] == '0)
        else $error("checksum counter out of range");

    // address fields count below four
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEST || state_reg == ST_SRC) |-> cnt_reg[CNT_W-1:2] == '0)
        else $error("address counter out of range");

    // a status result starts a fresh frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && state_reg == ST_SUM && !high_pos) |=>
            (state_reg == ST_DEST && cnt_reg == '0 && match_reg && !bad_reg))
        else $error("frame state not cleared after status");

    // payload results carry no status bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_PAYLOAD) |->
            (out_reg.source_address == '0 && out_reg.frame_bytes == '0))
        else $error("payload result with status fields");

endmodule

// ===== rtl/core/hex_ascii_frame_deframer.sv =====
// hex_ascii_frame_deframer: top level with apb register file and streaming ports
// depends on hafd_pkg, hafd_front, hafd_queue, hafd_back
// results pass from the queue through the field sequencer into the output register
// throughput: one character per cycle while the queue is not full
// the four-entry queue lets input keep flowing while a result waits on m_tready
// reset: async active low, clears frame state and queue, node address 0, frame limit 73
module hex_ascii_frame_deframer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // in_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // data_byte[7:0], source_address[23:8], frame_bytes[55:24], address_match[56],
    // checksum_ok[57], too_long[58], too_short[59], bad_digit[60], zero[63:61]
    output logic [63:0]                  m_tdata,
    output logic                         m_tuser,   // result_kind
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hafd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import hafd_pkg::*;

    logic [ADDR_W-1:0]   node_addr_reg;
    logic [MAXLEN_W-1:0] max_frame_reg;
    logic                cfg_write;
    hafd_push_t          push;
    hafd_qout_t          qout;
    logic                q_full;
    logic                pop;
    hafd_result_t        result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr_reg <= '0;
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_OWN_ADDR:  node_addr_reg <= pwdata;
                REG_MAX_FRAME: max_frame_reg <= pwdata[MAXLEN_W-1:0];
                default:       node_addr_reg <= node_addr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OWN_ADDR:  prdata = node_addr_reg;
            REG_MAX_FRAME: prdata = {16'd0, max_frame_reg};
            default:       prdata = '0;
        endcase
    end

    hafd_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    hafd_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .qout  (qout)
    );

    hafd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .qout            (qout),
        .pop             (pop),
        .node_addr       (node_addr_reg),
        .max_frame_bytes (max_frame_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_result        (result),
        .m_kind          (m_tuser)
    );

    assign m_tdata = result;

endmodule
